>>> hw/rtl/ipd_pkg.sv
// shared widths, register codes and types of the impact pulse detector
package ipd_pkg;

    localparam int SAMPLE_WIDTH    = 24;
    localparam int INDEX_WIDTH     = 32;
    localparam int THR_WIDTH       = 24;
    localparam int GAP_WIDTH       = 16;
    localparam int WIN_WIDTH       = 17;
    localparam int STEP_WIDTH      = 23;
    localparam int COUNT_WIDTH     = 16;
    localparam int CFG_DATA_WIDTH  = 24;
    localparam int CFG_INDEX_WIDTH = 3;

    // compare widths wide enough for both operands after sign or zero extension
    localparam int THR_CMP_WIDTH = (SAMPLE_WIDTH > THR_WIDTH) ? SAMPLE_WIDTH : THR_WIDTH;
    localparam int DIFF_WIDTH    = SAMPLE_WIDTH + 1;
    localparam int MAG_CMP_WIDTH = (DIFF_WIDTH > STEP_WIDTH) ? DIFF_WIDTH : STEP_WIDTH;

    localparam logic signed [THR_WIDTH-1:0] LOWER_THR_RST   = THR_WIDTH'(-51200);
    localparam logic signed [THR_WIDTH-1:0] UPPER_THR_RST   = THR_WIDTH'(-128000);
    localparam logic [GAP_WIDTH-1:0]        REBOUND_GAP_RST = GAP_WIDTH'(500);
    localparam logic [WIN_WIDTH-1:0]        WINDOW_LEN_RST  = WIN_WIDTH'(16384);
    localparam logic [STEP_WIDTH-1:0]       DOUBLE_STEP_RST = STEP_WIDTH'(2560);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_LOWER_THR   = 3'd0,
        REG_UPPER_THR   = 3'd1,
        REG_REBOUND_GAP = 3'd2,
        REG_WINDOW_LEN  = 3'd3,
        REG_DOUBLE_STEP = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [THR_WIDTH-1:0] lower_thr;
        logic signed [THR_WIDTH-1:0] upper_thr;
        logic [GAP_WIDTH-1:0]        rebound_gap;
        logic [WIN_WIDTH-1:0]        window_len;
        logic [STEP_WIDTH-1:0]       double_step;
    } cfg_t;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0]        peak_index;
        logic signed [SAMPLE_WIDTH-1:0] peak_force;
        logic [COUNT_WIDTH-1:0]        impact_number;
    } result_t;

endpackage

>>> hw/rtl/ipd_core.sv
// per-sample impact tracking: peak search, quiet window, double-hit check, judgment
module ipd_core
    import ipd_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  cfg_t                           cfg,
    output logic                           result_valid,
    output result_t                        result
);

    logic [INDEX_WIDTH-1:0]         sample_count_reg, sample_count_next;
    logic [WIN_WIDTH-1:0]           quiet_count_reg, quiet_count_next;
    logic                           armed_reg, armed_next;
    logic signed [SAMPLE_WIDTH-1:0] running_peak_reg, running_peak_next;
    logic [INDEX_WIDTH-1:0]         peak_position_reg, peak_position_next;
    logic                           double_hit_reg, double_hit_next;
    logic signed [SAMPLE_WIDTH-1:0] previous_sample_reg, previous_sample_next;
    logic [COUNT_WIDTH-1:0]         accepted_count_reg, accepted_count_next;

    logic signed [THR_CMP_WIDTH-1:0] x_ext, lower_ext, upper_ext, peak_ext;
    logic signed [DIFF_WIDTH-1:0]    diff;
    logic [DIFF_WIDTH-1:0]           mag;
    logic [WIN_WIDTH-1:0]            quiet_inc;
    logic                            is_quiet, is_new_peak, step_hit, window_done;
    logic                            peak_ok;

    assign x_ext     = THR_CMP_WIDTH'(sample);
    assign lower_ext = THR_CMP_WIDTH'($signed(cfg.lower_thr));
    assign upper_ext = THR_CMP_WIDTH'($signed(cfg.upper_thr));
    assign peak_ext  = THR_CMP_WIDTH'(running_peak_reg);

    assign is_quiet    = x_ext > lower_ext;
    assign is_new_peak = sample < running_peak_reg;
    assign peak_ok     = peak_ext > upper_ext;

    // quiet counter stops at the window length
    assign quiet_inc = (quiet_count_reg < cfg.window_len) ? quiet_count_reg + WIN_WIDTH'(1)
                                                         : quiet_count_reg;

    assign diff = DIFF_WIDTH'(sample) - DIFF_WIDTH'(previous_sample_reg);
    assign mag  = diff[DIFF_WIDTH-1] ? DIFF_WIDTH'(-diff) : DIFF_WIDTH'(diff);

    assign step_hit = (quiet_inc > WIN_WIDTH'(cfg.rebound_gap))
                   && (quiet_inc < cfg.window_len)
                   && (MAG_CMP_WIDTH'(mag) > MAG_CMP_WIDTH'(cfg.double_step));

    assign window_done = armed_reg && (quiet_inc >= cfg.window_len);

    always_comb
    begin
        sample_count_next    = sample_count_reg;
        quiet_count_next     = quiet_count_reg;
        armed_next           = armed_reg;
        running_peak_next    = running_peak_reg;
        peak_position_next   = peak_position_reg;
        double_hit_next      = double_hit_reg;
        previous_sample_next = previous_sample_reg;
        accepted_count_next  = accepted_count_reg;
        result_valid         = 1'b0;
        result.peak_index    = peak_position_reg;
        result.peak_force    = running_peak_reg;
        result.impact_number = accepted_count_reg + COUNT_WIDTH'(1);

        if (sample_valid)
        begin
            sample_count_next    = sample_count_reg + INDEX_WIDTH'(1);
            previous_sample_next = sample;
            if (is_quiet)
            begin
                quiet_count_next = quiet_inc;
                if (step_hit)
                begin
                    double_hit_next = 1'b1;
                end
                // a step hit and a finished window never coincide
                if (window_done)
                begin
                    if (!double_hit_reg && peak_ok)
                    begin
                        accepted_count_next = accepted_count_reg + COUNT_WIDTH'(1);
                        result_valid        = 1'b1;
                    end
                    else
                    begin
                        double_hit_next = 1'b0;
                    end
                    armed_next        = 1'b0;
                    running_peak_next = '0;
                end
            end
            else if (is_new_peak)
            begin
                running_peak_next  = sample;
                peak_position_next = sample_count_next;
                armed_next         = 1'b1;
                quiet_count_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg    <= '1;
            quiet_count_reg     <= '0;
            armed_reg           <= 1'b0;
            running_peak_reg    <= '0;
            peak_position_reg   <= '0;
            double_hit_reg      <= 1'b0;
            previous_sample_reg <= '0;
            accepted_count_reg  <= '0;
        end
        else
        begin
            sample_count_reg    <= sample_count_next;
            quiet_count_reg     <= quiet_count_next;
            armed_reg           <= armed_next;
            running_peak_reg    <= running_peak_next;
            peak_position_reg   <= peak_position_next;
            double_hit_reg      <= double_hit_next;
            previous_sample_reg <= previous_sample_next;
            accepted_count_reg  <= accepted_count_next;
        end
    end

endmodule

>>> hw/rtl/impact_pulse_detector.sv
// Impact pulse detector top level: takes one force sample per cycle while in_stall is low
// and gives the index, peak force and ordinal of each accepted hammer impact. A sample
// goes into an input register; the tracking state is updated from it as it leaves that
// register, and any result it causes is loaded into the output register at the same
// clock edge, or into the skid stage while the output is held. The output has a register
// and a one-entry skid stage, so samples keep flowing while a result waits; the input
// stalls only when both are full and a sample is waiting in the input register.
// Configuration writes are always ready and take effect on the next sample.
module impact_pulse_detector
    import ipd_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]    force_sample,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [INDEX_WIDTH-1:0]            peak_index,
    output logic signed [SAMPLE_WIDTH-1:0]    peak_force,
    output logic [COUNT_WIDTH-1:0]            impact_number,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]         cfg_data
);

    cfg_t                           cfg_reg;
    logic                           s1_valid_reg, s1_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] s1_sample_reg;
    logic                           in_accept, s1_advance;

    logic                           push;
    result_t                        core_result;
    result_t                        out_reg, skid_reg;
    logic                           out_valid_reg, out_valid_next;
    logic                           skid_valid_reg, skid_valid_next;
    logic                           pop, load_out, load_skid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lower_thr   <= LOWER_THR_RST;
            cfg_reg.upper_thr   <= UPPER_THR_RST;
            cfg_reg.rebound_gap <= REBOUND_GAP_RST;
            cfg_reg.window_len  <= WINDOW_LEN_RST;
            cfg_reg.double_step <= DOUBLE_STEP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LOWER_THR:   cfg_reg.lower_thr   <= cfg_data[THR_WIDTH-1:0];
                REG_UPPER_THR:   cfg_reg.upper_thr   <= cfg_data[THR_WIDTH-1:0];
                REG_REBOUND_GAP: cfg_reg.rebound_gap <= cfg_data[GAP_WIDTH-1:0];
                REG_WINDOW_LEN:  cfg_reg.window_len  <= cfg_data[WIN_WIDTH-1:0];
                REG_DOUBLE_STEP: cfg_reg.double_step <= cfg_data[STEP_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // input register holds while the skid stage is occupied
    assign s1_advance = s1_valid_reg && !skid_valid_reg;
    assign in_stall   = s1_valid_reg && skid_valid_reg;
    assign in_accept  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sample_reg <= force_sample;
        end
    end

    ipd_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (s1_advance),
        .sample       (s1_sample_reg),
        .cfg          (cfg_reg),
        .result_valid (push),
        .result       (core_result)
    );

    // output register with one skid entry behind it
    assign pop = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                load_out        = 1'b1;
                out_valid_next  = 1'b1;
                skid_valid_next = push;
                load_skid       = push;
            end
            else
            begin
                load_out       = push;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            load_skid       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= skid_valid_reg ? skid_reg : core_result;
        end
        if (load_skid)
        begin
            skid_reg <= core_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign peak_index    = out_reg.peak_index;
    assign peak_force    = out_reg.peak_force;
    assign impact_number = out_reg.impact_number;

endmodule

>>> hw/rtl/ipd_checker.sv
// port-level checks of the impact pulse detector and their binding
module ipd_checker
    import ipd_pkg::*;
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [INDEX_WIDTH-1:0]         peak_index,
    input logic signed [SAMPLE_WIDTH-1:0] peak_force,
    input logic [COUNT_WIDTH-1:0]         impact_number,
    input logic                           cfg_valid,
    input logic                           cfg_ready
);

    logic                   seen_reg;
    logic [COUNT_WIDTH-1:0] last_number_reg;
    logic                   out_accept;

    assign out_accept = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg        <= 1'b0;
            last_number_reg <= '0;
        end
        else if (out_accept)
        begin
            seen_reg        <= 1'b1;
            last_number_reg <= impact_number;
        end
    end

    // a stalled request keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(peak_index)
                                   && $stable(peak_force) && $stable(impact_number))
        else $error("stalled result changed");

    // ordinals of delivered impacts step by one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_accept && seen_reg |-> impact_number == last_number_reg + COUNT_WIDTH'(1))
        else $error("impact ordinal skipped or repeated");

    // a peak is always below zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> peak_force[SAMPLE_WIDTH-1])
        else $error("non-negative peak reported");

    // input only backs up when the output side is held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // configuration never blocks
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration request refused");

endmodule

bind impact_pulse_detector ipd_checker u_ipd_checker (.*);

>>> tb/impact_pulse_detector_tb.sv
// self-checking testbench of the impact pulse detector: predicted impacts against the block
`timescale 1ns / 100ps

module impact_pulse_detector_tb;
    import ipd_pkg::*;

    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEM_TARGET  = 1050;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [SAMPLE_WIDTH-1:0] force_sample;
    logic out_valid;
    logic out_stall;
    logic [INDEX_WIDTH-1:0] peak_index;
    logic signed [SAMPLE_WIDTH-1:0] peak_force;
    logic [COUNT_WIDTH-1:0] impact_number;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0] cfg_data;

    impact_pulse_detector uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .force_sample  (force_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .peak_index    (peak_index),
        .peak_force    (peak_force),
        .impact_number (impact_number),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    class impact_judge;
        int unsigned errors;
        result_t pending_impacts[$];
        int lower_thr;
        int upper_thr;
        int gap_len;
        int win_len;
        int step_max;
        bit [INDEX_WIDTH-1:0] sample_idx;
        int quiet;
        bit armed;
        int run_peak;
        bit [INDEX_WIDTH-1:0] peak_at;
        bit dbl_seen;
        int prev;
        bit [COUNT_WIDTH-1:0] ordinal;

        function new();
            errors = 0;
            lower_thr = -51200;
            upper_thr = -128000;
            gap_len = 500;
            win_len = 16384;
            step_max = 2560;
            sample_idx = '1;
            quiet = 0;
            armed = 1'b0;
            run_peak = 0;
            peak_at = '0;
            dbl_seen = 1'b0;
            prev = 0;
            ordinal = '0;
        endfunction

        task flag_mismatch(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        function int pending();
            return pending_impacts.size();
        endfunction

        function void set_register(cfg_reg_t idx, logic [CFG_DATA_WIDTH-1:0] data);
            case (idx)
                REG_LOWER_THR:   lower_thr = $signed(data[THR_WIDTH-1:0]);
                REG_UPPER_THR:   upper_thr = $signed(data[THR_WIDTH-1:0]);
                REG_REBOUND_GAP: gap_len = data[GAP_WIDTH-1:0];
                REG_WINDOW_LEN:  win_len = data[WIN_WIDTH-1:0];
                REG_DOUBLE_STEP: step_max = data[STEP_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        function void take_sample(logic signed [SAMPLE_WIDTH-1:0] s);
            int x;
            int d;
            result_t r;
            x = s;
            sample_idx = sample_idx + 1'b1;
            if (x > lower_thr)
            begin
                if (quiet < win_len)
                    quiet++;
                d = x - prev;
                if (d < 0)
                    d = -d;
                if (quiet > gap_len && quiet < win_len && d > step_max)
                    dbl_seen = 1'b1;
                // judgement once a full quiet window follows the peak
                if (armed && quiet >= win_len)
                begin
                    if (!dbl_seen && run_peak > upper_thr)
                    begin
                        ordinal = ordinal + 1'b1;
                        r.peak_index = peak_at;
                        r.peak_force = SAMPLE_WIDTH'(run_peak);
                        r.impact_number = ordinal;
                        pending_impacts.insert(pending_impacts.size(), r);
                    end
                    else
                    begin
                        dbl_seen = 1'b0;
                    end
                    armed = 1'b0;
                    run_peak = 0;
                end
            end
            else if (x < run_peak)
            begin
                run_peak = x;
                peak_at = sample_idx;
                armed = 1'b1;
                quiet = 0;
            end
            prev = x;
        endfunction

        task check_impact(logic [INDEX_WIDTH-1:0] idx, logic signed [SAMPLE_WIDTH-1:0] f,
                          logic [COUNT_WIDTH-1:0] n);
            result_t want;
            if (pending_impacts.size() == 0)
            begin
                flag_mismatch($sformatf("impact at index %0d with no request behind it", idx));
            end
            else
            begin
                want = pending_impacts.pop_front();
                if (idx !== want.peak_index)
                    flag_mismatch($sformatf("peak_index %0d, want %0d", idx, want.peak_index));
                if (f !== want.peak_force)
                    flag_mismatch($sformatf("peak_force %0d, want %0d", f,
                                            $signed(want.peak_force)));
                if (n !== want.impact_number)
                    flag_mismatch($sformatf("impact_number %0d, want %0d", n,
                                            want.impact_number));
            end
        endtask
    endclass

    impact_judge judge;
    logic signed [SAMPLE_WIDTH-1:0] sample_plan[$];
    bit tx_burst;
    bit rx_burst;
    bit hold_request;
    int items_sent;
    int cycles;
    int cfg_lower;
    int cfg_upper;
    int cfg_gap;
    int cfg_win;
    int cfg_step;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                judge.take_sample(force_sample);
            if (out_valid && !out_stall)
                judge.check_impact(peak_index, peak_force, impact_number);
        end
    end

    // result side: random hold-off per result, one long hold when asked
    initial
    begin : receiver
        int hold;
        out_stall = 1'b0;
        rx_burst = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold = LONG_HOLD;
                hold_request = 1'b0;
            end
            else
            begin
                hold = rx_burst ? 0 : $urandom_range(13, 0);
            end
            if ($urandom_range(39, 0) == 0)
                rx_burst = !rx_burst;
            @(negedge clk);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_WIDTH-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        judge.set_register(idx, data);
    endtask

    // junk fills the unused upper bits of the narrower registers
    task automatic program_detector(int lo, int up, int gap, int win, int step, bit junk);
        logic [CFG_DATA_WIDTH-1:0] fill;
        cfg_lower = lo;
        cfg_upper = up;
        cfg_gap = gap;
        cfg_win = win;
        cfg_step = step;
        fill = junk ? CFG_DATA_WIDTH'($urandom) : '0;
        write_reg(REG_LOWER_THR, CFG_DATA_WIDTH'(lo));
        write_reg(REG_UPPER_THR, CFG_DATA_WIDTH'(up));
        write_reg(REG_REBOUND_GAP, CFG_DATA_WIDTH'(gap) | (fill << GAP_WIDTH));
        write_reg(REG_WINDOW_LEN, CFG_DATA_WIDTH'(win) | (fill << WIN_WIDTH));
        write_reg(REG_DOUBLE_STEP, CFG_DATA_WIDTH'(step) | (fill << STEP_WIDTH));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_plan();
        int gap;
        logic signed [SAMPLE_WIDTH-1:0] s;
        while (sample_plan.size() > 0)
        begin
            gap = tx_burst ? 0 : $urandom_range(13, 0);
            s = sample_plan.pop_front();
            @(negedge clk);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            force_sample <= s;
            do
                @(posedge clk);
            while (in_stall);
            items_sent++;
            if ($urandom_range(59, 0) == 0)
                tx_burst = !tx_burst;
        end
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (judge.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic plan_values(int vals[]);
        foreach (vals[i])
            sample_plan.insert(sample_plan.size(), SAMPLE_WIDTH'(vals[i]));
    endtask

    task automatic plan_noise(int n);
        repeat (n)
            sample_plan.insert(sample_plan.size(), SAMPLE_WIDTH'($urandom));
    endtask

    // small wiggle around zero, with an optional step big enough to be a double hit
    task automatic plan_quiet(int n, int jump_pos);
        int amp;
        int v;
        amp = cfg_step / 4;
        if (amp > -cfg_lower / 2)
            amp = -cfg_lower / 2;
        if (amp < 0)
            amp = 0;
        for (int j = 1; j <= n; j++)
        begin
            v = int'($urandom_range(2 * amp, 0)) - amp;
            if (j == jump_pos)
                v = amp + cfg_step + 1 + int'($urandom_range(100, 0));
            sample_plan.insert(sample_plan.size(), SAMPLE_WIDTH'(v));
        end
    endtask

    task automatic plan_impact();
        int pk;
        int jump_pos;
        if ($urandom_range(7, 0) == 0)
            pk = cfg_upper - int'($urandom_range(5000, 0));
        else
            pk = cfg_upper + 1 + int'($urandom_range(cfg_lower - cfg_upper - 2, 0));
        jump_pos = 0;
        if ($urandom_range(5, 0) == 0 && cfg_gap + 1 <= cfg_win - 1)
            jump_pos = $urandom_range(cfg_win - 1, cfg_gap + 1);
        plan_quiet($urandom_range(3, 0), 0);
        sample_plan.insert(sample_plan.size(), SAMPLE_WIDTH'((cfg_lower + pk) / 2));
        sample_plan.insert(sample_plan.size(), SAMPLE_WIDTH'(pk));
        sample_plan.insert(sample_plan.size(), SAMPLE_WIDTH'((cfg_lower + pk) / 2));
        plan_quiet(cfg_win + $urandom_range(3, 0), jump_pos);
    endtask

    task automatic plan_tidy_phase(int n_items);
        while (sample_plan.size() < n_items)
        begin
            case ($urandom_range(9, 0))
                0: plan_noise($urandom_range(6, 1));
                1: plan_quiet($urandom_range(cfg_win + 1, 1), $urandom_range(cfg_win, 0));
                default: plan_impact();
            endcase
        end
    endtask

    task automatic tidy_config();
        int lo;
        int up;
        int win;
        int gap;
        lo = -int'($urandom_range(20000, 300));
        up = lo - int'($urandom_range(30000, 1000));
        win = $urandom_range(24, 2);
        case ($urandom_range(7, 0))
            0: gap = 0;
            1: gap = win + $urandom_range(5, 0);
            default: gap = $urandom_range(win, 1);
        endcase
        program_detector(lo, up, gap, win, $urandom_range(3000, 50), $urandom_range(1, 0));
    endtask

    initial
    begin : main
        int d1[];
        int d2[];
        int d3[];
        int win;
        judge = new();
        cycles = 0;
        items_sent = 0;
        tx_burst = 1'b0;
        hold_request = 1'b0;
        in_valid = 1'b0;
        force_sample = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_LOWER_THR;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // peak at the most negative code is rejected, a later moderate one accepted
        d1 = '{0, 8388607, -8388608, 1, 2, 3, 4, -60000, -70000, -55000, 100, 100, 100, 100};
        program_detector(-51200, -8388608, 1, 4, 8388607, 1'b0);
        plan_values(d1);
        send_plan();
        wait_idle();

        // window of zero: every quiet sample judges at once
        d2 = '{-200, 5, -300, -400, 7};
        program_detector(-100, -8388608, 0, 0, 0, 1'b0);
        plan_values(d2);
        send_plan();
        wait_idle();

        // register extremes for the thresholds and the rebound gap, window of 65536
        d3 = '{-8388608, 8388607, -8388607};
        program_detector(-8388608, 8388607, 65535, 65536, 0, 1'b0);
        plan_values(d3);
        send_plan();
        wait_idle();

        // short windows back to back while the result side holds off
        program_detector(-5000, -40000, 2, 3, 2000, 1'b0);
        tx_burst = 1'b1;
        hold_request = 1'b1;
        plan_tidy_phase(200);
        send_plan();
        wait_idle();
        tx_burst = 1'b0;

        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(5, 0) == 0)
            begin
                win = ($urandom_range(3, 0) == 0) ? $urandom_range(131071, 0)
                                                  : $urandom_range(12, 0);
                program_detector($signed(SAMPLE_WIDTH'($urandom)), $signed(SAMPLE_WIDTH'($urandom)),
                                 $urandom_range(65535, 0), win, $urandom_range(8388607, 0), 1'b1);
                plan_noise($urandom_range(80, 30));
            end
            else
            begin
                tidy_config();
                plan_tidy_phase($urandom_range(120, 40));
            end
            send_plan();
            wait_idle();
        end

        if (judge.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
